// File: src/hef_pkg.sv
// ----------------------------------------------------------------------------
// hef_pkg
// Shared types and constants for the histogram extrema finder.
// ----------------------------------------------------------------------------
`default_nettype none

package hef_pkg;

    // Kind of a reported result
    typedef enum logic [1:0] {
        KIND_MIN = 2'd0,
        KIND_MAX = 2'd1,
        KIND_END = 2'd2
    } t_kind;

    // Where a result came from
    typedef enum logic [1:0] {
        SRC_ENDPOINT = 2'd0,
        SRC_INTERIOR = 2'd1,
        SRC_RISE     = 2'd2,
        SRC_FALL     = 2'd3
    } t_src;

    // Result slots per sample, in output order
    localparam int NUM_SLOTS   = 4;
    localparam int SLOT_EDGE0  = 0;   // interior point or first endpoint
    localparam int SLOT_RISE   = 1;
    localparam int SLOT_ENDPT  = 2;   // closing endpoint
    localparam int SLOT_CLOSE  = 3;   // last fall or bare end marker

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] THRESH_RESET = 16'd655;

    // Register map (byte addresses)
    localparam int          CFG_AW                 = 3;
    localparam logic [CFG_AW-1:0] ADDR_ZERO_THRESHOLD = 3'd0;

    typedef struct packed {
        logic [7:0] position;
        t_kind      kind;
        t_src       source;
    } t_result;

    // All results one sample causes
    typedef struct packed {
        t_result [NUM_SLOTS-1:0] slot;
        logic    [NUM_SLOTS-1:0] mask;
        logic                    eop;
    } t_bundle;

endpackage

`default_nettype wire

// File: src/hef_front.sv
// ----------------------------------------------------------------------------
// hef_front
// Thresholds samples, runs the three-sample window and builds one result
// bundle per sample.
// ----------------------------------------------------------------------------
`default_nettype none

module hef_front import hef_pkg::*; #(
    parameter int MAX_LENGTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_threshold,
    input  wire logic        i_valid,
    input  wire logic [15:0] i_sample,
    input  wire logic        i_last,
    input  wire logic        i_q_full,
    output logic             o_ready,
    output logic             o_push,
    output t_bundle          o_bundle
);

    localparam int CW = $clog2(MAX_LENGTH);
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_LENGTH - 1);

    logic [15:0]   r_older, r_newer;
    logic [CW-1:0] r_count;
    logic          r_rise_seen;
    logic [7:0]    r_fall_pos;
    logic          r_fall_seen;

    logic          accept, ending, j0, j1, jn;
    logic [15:0]   v;
    logic [CW-1:0] jm1;
    logic [CW+7:0] j_ext, jm1_ext;
    logic [7:0]    pos_j, pos_jm1;
    logic          fall_now, fall_seen_eff, rise_now;
    logic [7:0]    fall_pos_eff;
    t_bundle       b;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        v        = (i_sample < i_threshold) ? 16'd0 : i_sample;
        j0       = (r_count == '0);
        j1       = (r_count == CW'(1));
        jn       = !j0 && !j1;
        ending   = i_last || (r_count == LAST_IDX);
        jm1      = r_count - CW'(1);
        j_ext    = {8'd0, r_count};
        jm1_ext  = {8'd0, jm1};
        pos_j    = j_ext[7:0];
        pos_jm1  = jm1_ext[7:0];

        rise_now      = jn && !r_rise_seen && (r_newer == 16'd0) && (v != 16'd0);
        fall_now      = jn && (v == 16'd0) && (r_newer != 16'd0);
        fall_seen_eff = r_fall_seen || fall_now;
        fall_pos_eff  = fall_now ? pos_jm1 : r_fall_pos;

        b = '0;
        // first endpoint or interior point at j-1
        if (j1) begin
            b.slot[SLOT_EDGE0] = '{8'd0, (r_newer > v) ? KIND_MAX : KIND_MIN, SRC_ENDPOINT};
            b.mask[SLOT_EDGE0] = (r_newer != v);
        end else if (jn) begin
            b.slot[SLOT_EDGE0].position = pos_jm1;
            b.slot[SLOT_EDGE0].source   = SRC_INTERIOR;
            if (r_older > r_newer && r_newer < v) begin
                b.slot[SLOT_EDGE0].kind = KIND_MIN;
                b.mask[SLOT_EDGE0]      = 1'b1;
            end else if (r_older < r_newer && r_newer > v) begin
                b.slot[SLOT_EDGE0].kind = KIND_MAX;
                b.mask[SLOT_EDGE0]      = 1'b1;
            end
        end
        b.slot[SLOT_RISE] = '{pos_j, KIND_MIN, SRC_RISE};
        b.mask[SLOT_RISE] = rise_now;

        b.slot[SLOT_ENDPT] = '{pos_j, (v > r_newer) ? KIND_MAX : KIND_MIN, SRC_ENDPOINT};
        b.mask[SLOT_ENDPT] = ending && !j0 && (v != r_newer);

        if (fall_seen_eff) begin
            b.slot[SLOT_CLOSE] = '{fall_pos_eff, KIND_MIN, SRC_FALL};
            b.mask[SLOT_CLOSE] = ending;
        end else begin
            b.slot[SLOT_CLOSE] = '{pos_j, KIND_END, SRC_ENDPOINT};
            b.mask[SLOT_CLOSE] = ending && (b.mask[SLOT_ENDPT:SLOT_EDGE0] == '0);
        end
        b.eop = ending;
    end

    assign o_bundle = b;
    assign o_push   = accept && (b.mask != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older     <= '0;
            r_newer     <= '0;
            r_count     <= '0;
            r_rise_seen <= 1'b0;
            r_fall_pos  <= '0;
            r_fall_seen <= 1'b0;
        end else if (accept) begin
            if (ending) begin
                r_older     <= '0;
                r_newer     <= '0;
                r_count     <= '0;
                r_rise_seen <= 1'b0;
                r_fall_pos  <= '0;
                r_fall_seen <= 1'b0;
            end else begin
                r_older     <= r_newer;
                r_newer     <= v;
                r_count     <= r_count + CW'(1);
                r_rise_seen <= r_rise_seen || rise_now;
                r_fall_pos  <= fall_pos_eff;
                r_fall_seen <= fall_seen_eff;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/hef_queue.sv
// ----------------------------------------------------------------------------
// hef_queue
// Small bundle FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module hef_queue import hef_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  t_bundle      i_data,
    input  wire logic    i_pop,
    output logic         o_full,
    output logic         o_empty,
    output t_bundle      o_head
);

    t_bundle               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/hef_back.sv
// ----------------------------------------------------------------------------
// hef_back
// Drains the head bundle one result per transfer into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hef_back import hef_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_empty,
    input  t_bundle       i_head,
    output logic          o_pop,
    input  wire logic     i_ready,
    output logic          o_valid,
    output t_result       o_result,
    output logic          o_eop
);

    logic [NUM_SLOTS-1:0] r_sent, pending, sel, rest;
    logic                 r_valid, r_eop, load;
    t_result              r_result, pick;

    always_comb begin
        pending = i_head.mask & ~r_sent;
        sel     = pending & (~pending + NUM_SLOTS'(1));   // lowest pending slot
        rest    = pending & ~sel;
        load    = !i_empty && (!r_valid || i_ready);
        o_pop   = load && (rest == '0);
        pick    = i_head.slot[SLOT_EDGE0];
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (sel[k]) pick = i_head.slot[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sent  <= o_pop ? '0 : (r_sent | sel);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= pick;
            r_eop    <= i_head.eop && (rest == '0);
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_eop    = r_eop;

endmodule

`default_nettype wire

// File: src/histogram_extrema_finder_unit.sv
// ----------------------------------------------------------------------------
// histogram_extrema_finder_unit
// Streams a 1-D profile and reports its local minima and maxima.
// ----------------------------------------------------------------------------
// Path: a sample transfer writes its result bundle into the queue at the
//   accepting edge when it yields any result; the output register loads
//   from the queue head whenever it is empty or its result is being taken.
// Throughput: one sample per cycle while each yields at most one result and
//   tready is high; the output register moves one result per ready cycle,
//   and multi-result samples stall input once the 4-entry queue fills.
// Reset: synchronous, active low; clears the window, flags, queue and output
//   valid, and loads zero_threshold with 655.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_extrema_finder_unit import hef_pkg::*; #(
    parameter int MAX_LENGTH = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // sample stream
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [15:0]       i_s_axis_tdata,   // [15:0] sample
    input  wire logic              i_s_axis_tlast,   // last sample of profile
    // result stream
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [7:0]             o_m_axis_tdata,   // [7:0] position
    output logic [3:0]             o_m_axis_tuser,   // [1:0] kind, [3:2] source
    output logic                   o_m_axis_tlast,   // end_of_profile
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [15:0] r_threshold;
    logic        cfg_hit;

    // Only one register; word aligned decode on paddr[2].
    assign cfg_hit = (paddr[2] == ADDR_ZERO_THRESHOLD[2]);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? {16'd0, r_threshold} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_threshold <= pwdata[15:0];
        end
    end

    // Front: threshold, window compare, bundle build
    logic    q_full, q_empty, push, pop;
    t_bundle push_bundle, head;

    hef_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_valid     (i_s_axis_tvalid),
        .i_sample    (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_q_full    (q_full),
        .o_ready     (o_s_axis_tready),
        .o_push      (push),
        .o_bundle    (push_bundle)
    );

    // Decouples sample acceptance from output backpressure
    hef_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_bundle),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    // Back: serializes bundle slots onto the result stream
    t_result res;

    hef_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_head   (head),
        .o_pop    (pop),
        .i_ready  (i_m_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_result (res),
        .o_eop    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = res.position;
    assign o_m_axis_tuser = {res.source, res.kind};

endmodule

`default_nettype wire

// File: src/hef_checker.sv
// ----------------------------------------------------------------------------
// hef_checker
// Port-level checks on the extrema finder's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module hef_checker import hef_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_m_axis_tvalid,
    input wire logic              i_m_axis_tready,
    input wire logic [7:0]        o_m_axis_tdata,
    input wire logic [3:0]        o_m_axis_tuser,
    input wire logic              o_m_axis_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // an end marker closes the profile and is tagged as endpoint
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[1:0] == KIND_END) |->
            o_m_axis_tlast && (o_m_axis_tuser[3:2] == SRC_ENDPOINT))
        else $error("malformed end marker");

    // zero rise and fall results are minima
    a_zero_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && ((o_m_axis_tuser[3:2] == SRC_RISE) ||
                            (o_m_axis_tuser[3:2] == SRC_FALL)) |->
            (o_m_axis_tuser[1:0] == KIND_MIN))
        else $error("zero crossing not reported as minimum");

    // no result directly out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind histogram_extrema_finder_unit hef_checker u_hef_checker (.*);

`default_nettype wire

// File: bench/hef_extrema_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hef_extrema_checker
// Watches the sample, result and register ports of the extrema finder,
// works out the extrema each accepted sample must produce and compares them
// in order against the result stream.
// ----------------------------------------------------------------------------
module hef_extrema_checker import hef_pkg::*; #(
    parameter int MAX_LENGTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [15:0]       i_s_tdata,
    input  logic              i_s_tlast,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [7:0]        i_m_tdata,
    input  logic [3:0]        i_m_tuser,
    input  logic              i_m_tlast,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    input  logic              i_pready,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [7:0] position;
        t_kind      kind;
        t_src       source;
        logic       eop;
    } t_extremum;

    t_extremum   expected_extrema[$];

    logic [15:0] zero_thr;
    logic [15:0] older_val;
    logic [15:0] newer_val;
    int          seen_count;
    bit          rise_seen;
    logic [7:0]  fall_pos;
    bit          fall_seen;

    task automatic restart_profile();
        older_val  = '0;
        newer_val  = '0;
        seen_count = 0;
        rise_seen  = 1'b0;
        fall_pos   = '0;
        fall_seen  = 1'b0;
    endtask

    task automatic note_extremum(input int pos, input t_kind kind, input t_src src);
        t_extremum e;
        e.position = pos[7:0];
        e.kind     = kind;
        e.source   = src;
        e.eop      = 1'b0;
        expected_extrema.insert(expected_extrema.size(), e);
    endtask

    // Extrema caused by one accepted sample, appended in output order
    task automatic find_extrema(input logic [15:0] raw, input logic is_last);
        logic [15:0] v;
        int          j;
        bit          ending;
        int          n_before;
        int          idx;
        t_extremum   tail;
        v        = (raw < zero_thr) ? 16'd0 : raw;
        j        = seen_count;
        ending   = is_last || (j + 1 >= MAX_LENGTH);
        n_before = expected_extrema.size();

        if (j == 1) begin
            // leading endpoint against its only neighbour
            if (newer_val > v)
                note_extremum(0, KIND_MAX, SRC_ENDPOINT);
            else if (newer_val < v)
                note_extremum(0, KIND_MIN, SRC_ENDPOINT);
        end else if (j >= 2) begin
            if (older_val > newer_val && newer_val < v)
                note_extremum(j - 1, KIND_MIN, SRC_INTERIOR);
            else if (older_val < newer_val && newer_val > v)
                note_extremum(j - 1, KIND_MAX, SRC_INTERIOR);
            if (!rise_seen && newer_val == 0 && v != 0) begin
                note_extremum(j, KIND_MIN, SRC_RISE);
                rise_seen = 1'b1;
            end
            if (v == 0 && newer_val != 0) begin
                fall_pos  = 8'((j - 1) & 'hFF);
                fall_seen = 1'b1;
            end
        end

        if (ending) begin
            // trailing endpoint; a lone sample has nothing to compare with
            if (j > 0) begin
                if (v > newer_val)
                    note_extremum(j, KIND_MAX, SRC_ENDPOINT);
                else if (v < newer_val)
                    note_extremum(j, KIND_MIN, SRC_ENDPOINT);
            end
            if (fall_seen)
                note_extremum(fall_pos, KIND_MIN, SRC_FALL);
            if (expected_extrema.size() == n_before)
                note_extremum(j, KIND_END, SRC_ENDPOINT);
            idx      = expected_extrema.size() - 1;
            tail     = expected_extrema[idx];
            tail.eop = 1'b1;
            expected_extrema[idx] = tail;
            restart_profile();
        end else begin
            older_val  = newer_val;
            newer_val  = v;
            seen_count = j + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_extremum want;
        if (!i_rst_n) begin
            zero_thr = THRESH_RESET;
            restart_profile();
            expected_extrema.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr == ADDR_ZERO_THRESHOLD)
                zero_thr = i_pwdata[15:0];

            // compare first: a sample accepted now cannot have a result out yet
            if (i_m_tvalid && i_m_tready) begin
                if (expected_extrema.size() == 0) begin
                    $display("%0t: unexpected result pos=%0d kind=%0d src=%0d eop=%0b",
                             $time, i_m_tdata, i_m_tuser[1:0], i_m_tuser[3:2],
                             i_m_tlast);
                    o_fail_count++;
                end else begin
                    want = expected_extrema.pop_front();
                    if (i_m_tdata !== want.position || i_m_tuser[1:0] !== want.kind
                            || i_m_tuser[3:2] !== want.source
                            || i_m_tlast !== want.eop) begin
                        $display({"%0t: mismatch expected pos=%0d kind=%0d src=%0d ",
                                  "eop=%0b actual pos=%0d kind=%0d src=%0d eop=%0b"},
                                 $time, want.position, want.kind, want.source,
                                 want.eop, i_m_tdata, i_m_tuser[1:0],
                                 i_m_tuser[3:2], i_m_tlast);
                        o_fail_count++;
                    end
                end
            end

            if (i_s_tvalid && i_s_tready)
                find_extrema(i_s_tdata, i_s_tlast);
        end
        o_pending = expected_extrema.size();
    end

endmodule

// File: bench/histogram_extrema_finder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_extrema_finder_unit_tb
// Drives profiles into the extrema finder under several thresholds and
// backpressure patterns; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module histogram_extrema_finder_unit_tb;
    import hef_pkg::*;

    localparam int MAX_LEN    = 256;
    localparam int HOLD_CYC   = 300;   // long receiver stall, fills the queue
    localparam int QUIET_CYC  = 8;     // margin after the last result drains

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_s_axis_tvalid  = 1'b0;
    logic              o_s_axis_tready;
    logic [15:0]       i_s_axis_tdata   = '0;     // [15:0] sample
    logic              i_s_axis_tlast   = 1'b0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready  = 1'b0;
    logic [7:0]        o_m_axis_tdata;            // [7:0] position
    logic [3:0]        o_m_axis_tuser;            // [1:0] kind, [3:2] source
    logic              o_m_axis_tlast;
    logic              psel             = 1'b0;
    logic              penable          = 1'b0;
    logic              pwrite           = 1'b0;
    logic [CFG_AW-1:0] paddr            = '0;
    logic [31:0]       pwdata           = '0;
    logic [31:0]       prdata;
    logic              pready;

    int fail_count;
    int pending;

    // Idle percentages, changed by the stimulus between rounds
    int tx_idle_pct = 35;
    int rx_idle_pct = 71;

    // Stall handshake: stimulus bumps hold_req, receiver serves it once
    int hold_req    = 0;
    int hold_served = 0;
    int hold_left   = 0;

    logic [15:0] cur_thr = THRESH_RESET;   // threshold the block holds now

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    histogram_extrema_finder_unit #(.MAX_LENGTH(MAX_LEN)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    hef_extrema_checker #(.MAX_LENGTH(MAX_LEN)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tlast    (i_s_axis_tlast),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tuser    (o_m_axis_tuser),
        .i_m_tlast    (o_m_axis_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result-side backpressure. A requested hold keeps tready low while
    // hold_left counts down from HOLD_CYC, regardless of the idle percentage.
    always @(posedge i_clk) begin
        if (hold_req != hold_served) begin
            hold_left   = HOLD_CYC;
            hold_served = hold_req;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    // One sample transfer. tvalid stays high from one sample to the next when
    // no gap is drawn, so it never gets two NBAs in one step.
    task automatic send_sample(input logic [15:0] s, input logic lst);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        i_s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Drop tvalid and let every outstanding result drain before touching
    // the register; some samples produce nothing, so pad with an idle margin.
    task automatic wait_quiet();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (QUIET_CYC) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [15:0] thr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ZERO_THRESHOLD;
        pwdata  <= {16'd0, thr};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_thr = thr;
    endtask

    // Sample mix aimed at the interesting compares: zero, just under and at
    // the threshold, full scale, plateaus, and plain random values.
    function automatic logic [15:0] pick_sample(input logic [15:0] prev);
        case ($urandom_range(9, 0))
            0:       return 16'd0;
            1:       return (cur_thr == 0) ? 16'd0 : 16'($urandom_range(cur_thr - 1, 0));
            2:       return cur_thr;
            3:       return 16'hFFFF;
            4, 5:    return prev;
            default: return 16'($urandom);
        endcase
    endfunction

    // Whole profiles of random length, mostly short, now and then longer
    task automatic run_profiles(input int n_items);
        int          sent;
        int          len;
        logic [15:0] prev;
        logic [15:0] s;
        sent = 0;
        prev = '0;
        while (sent < n_items) begin
            len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13)
                                               : $urandom_range(12, 1);
            for (int k = 0; k < len; k++) begin
                s = pick_sample(prev);
                send_sample(s, k == len - 1);
                prev = s;
                sent++;
            end
        end
    endtask

    // Runs past MAX_LEN with tlast low: the block must cut it at index 255
    // and start a fresh profile with the leftover samples.
    task automatic run_overlong();
        logic [15:0] prev;
        logic [15:0] s;
        prev = '0;
        for (int k = 0; k < MAX_LEN + 2; k++) begin
            s = pick_sample(prev);
            send_sample(s, k == MAX_LEN + 1);
            prev = s;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed profiles, reset threshold of 655 ---
        // lone sample: bare end marker at position 0
        send_sample(16'hFFFF, 1'b1);
        // both samples cleared to zero: flat, bare end marker at index 1
        send_sample(16'd654, 1'b0);
        send_sample(16'd0,   1'b1);
        // rise from zero, interior max, plateau, fall to zero, interior min, max and
        // min again, closing endpoint max plus the remembered fall
        send_sample(16'd0,     1'b0);
        send_sample(16'd0,     1'b0);
        send_sample(16'd40000, 1'b0);
        send_sample(16'hFFFF,  1'b0);
        send_sample(16'd12000, 1'b0);
        send_sample(16'd12000, 1'b0);
        send_sample(16'd3000,  1'b0);
        send_sample(16'd100,   1'b0);
        send_sample(16'd50000, 1'b0);
        send_sample(16'd20000, 1'b0);
        send_sample(16'd21000, 1'b1);
        // two-sample descent: endpoint max then endpoint min
        send_sample(16'd30000, 1'b0);
        send_sample(16'd1000,  1'b1);
        // threshold boundary and equal trailing neighbours
        send_sample(16'd655,   1'b0);
        send_sample(16'd800,   1'b0);
        send_sample(16'd800,   1'b1);

        // --- round 0: threshold 0, sender idles 35%, receiver 71% ---
        wait_quiet();
        write_threshold(16'd0);
        run_profiles(30);

        // --- round 1: threshold full scale, idling swapped ---
        wait_quiet();
        tx_idle_pct = 71;
        rx_idle_pct = 35;
        write_threshold(16'hFFFF);
        run_profiles(25);

        // --- round 2: random threshold, plus one overlong profile ---
        wait_quiet();
        write_threshold(16'($urandom));
        run_profiles(25);
        run_overlong();

        // --- round 3: reset threshold again, no idling, long result stall ---
        wait_quiet();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_threshold(THRESH_RESET);
        hold_req++;
        run_profiles(25);

        wait_quiet();
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/hef_pkg.sv
src/hef_front.sv
src/hef_queue.sv
src/hef_back.sv
src/histogram_extrema_finder_unit.sv
src/hef_checker.sv
bench/hef_extrema_checker.sv
bench/histogram_extrema_finder_unit_tb.sv
